// ===== rtl/core/dosage_r2_estimator_macros.svh =====
// Assertion helpers for the dosage r2 estimator checker.
`ifndef DOSAGE_R2_ESTIMATOR_MACROS_SVH
`define DOSAGE_R2_ESTIMATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DRE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dosage r2 estimator check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dosage r2 estimator check failed");

`endif

// ===== rtl/core/dre_pkg.sv =====
package dre_pkg;

  localparam int unsigned MaxHaps   = 4096;
  localparam int unsigned CntW      = 13;
  localparam int unsigned DosW      = 16;
  localparam int unsigned SqDosW    = 31;
  localparam int unsigned SumW      = 28;
  localparam int unsigned SqSumW    = 43;
  localparam int unsigned MulW      = 28;
  localparam int unsigned AluW      = 2 * MulW;
  localparam int unsigned QLoW      = 22;
  localparam int unsigned QHiW      = SqSumW - QLoW;
  localparam int unsigned NHiW      = CntW + QHiW;
  localparam int unsigned FracW     = 15;
  localparam int unsigned StepW     = 4;
  localparam int unsigned PDivSteps = 16;
  localparam int unsigned RDivSteps = 15;

  localparam logic [DosW-1:0] OneQ15  = 16'd32768;
  localparam logic [DosW-1:0] HalfQ15 = 16'd16384;

  typedef enum logic {
    REG_THR = 1'b0,
    REG_MAF = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PDIV,
    ST_FMS,
    ST_SQ,
    ST_NLO,
    ST_NHI,
    ST_NADD,
    ST_NSUB,
    ST_DEN,
    ST_CMP,
    ST_RDIV,
    ST_FIN
  } seq_state_e;

  typedef struct packed {
    logic [DosW-1:0] dosage;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [DosW-1:0]  allele_freq;
    logic [DosW-1:0]  r2_value;
    logic [FracW-1:0] minor_freq;
    logic             minor_freq_valid;
    logic [CntW-1:0]  hap_count;
    logic             count_overflow;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0]   count;
    logic [SumW-1:0]   sum;
    logic [SqSumW-1:0] sq_sum;
    logic              overflow;
  } acc_stat_t;

  typedef struct packed {
    alu_op_e         op;
    logic [AluW-1:0] opa;
    logic [AluW-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0] res;
    logic            ge;
  } alu_rsp_t;

endpackage

// ===== rtl/core/dre_accum.sv =====
module dre_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  dre_pkg::in_item_t item_i,
  output dre_pkg::acc_stat_t stat_o,
  output logic              done_o
);
  import dre_pkg::*;

  logic [DosW-1:0]   dose_c;
  logic [SqDosW-1:0] sq_c;

  logic              s1_valid_q, s1_last_q;
  logic [DosW-1:0]   s1_dose_q;
  logic [SqDosW-1:0] s1_sq_q;

  logic [CntW-1:0]   count_q;
  logic [SumW-1:0]   sum_q;
  logic [SqSumW-1:0] sq_sum_q;
  logic              ovf_q;
  logic              done_q;

  // Saturate dosages above one.
  assign dose_c = (item_i.dosage > OneQ15) ? OneQ15 : item_i.dosage;
  assign sq_c   = SqDosW'(dose_c * dose_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= item_valid_i;
      s1_last_q  <= item_valid_i & item_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      s1_dose_q <= dose_c;
      s1_sq_q   <= sq_c;
    end
  end

  // Clear on the cycle the sequencer captures the totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      sq_sum_q <= '0;
      ovf_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= s1_valid_q & s1_last_q;
      if (done_q) begin
        count_q  <= '0;
        sum_q    <= '0;
        sq_sum_q <= '0;
        ovf_q    <= 1'b0;
      end else if (s1_valid_q) begin
        if (count_q < CntW'(MaxHaps)) begin
          count_q  <= count_q + 1'b1;
          sum_q    <= sum_q + SumW'(s1_dose_q);
          sq_sum_q <= sq_sum_q + SqSumW'(s1_sq_q);
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o = '{count: count_q, sum: sum_q, sq_sum: sq_sum_q, overflow: ovf_q};
  assign done_o = done_q;

endmodule

// ===== rtl/core/dre_alu.sv =====
module dre_alu (
  input  dre_pkg::alu_req_t req_i,
  output dre_pkg::alu_rsp_t rsp_o
);
  import dre_pkg::*;

  logic [AluW-1:0] prod;
  logic [AluW-1:0] res;

  assign prod = AluW'(req_i.opa[MulW-1:0] * req_i.opb[MulW-1:0]);

  always_comb begin
    unique case (req_i.op)
      ALU_MUL: res = prod;
      ALU_ADD: res = req_i.opa + req_i.opb;
      ALU_SUB: res = req_i.opa - req_i.opb;
      default: res = '0;
    endcase
  end

  assign rsp_o = '{res: res, ge: (req_i.opa >= req_i.opb)};

endmodule

// ===== rtl/core/dre_seq.sv =====
module dre_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  dre_pkg::acc_stat_t stat_i,
  input  logic [15:0]        thr_i,
  input  logic               maf_en_i,
  output dre_pkg::alu_req_t  alu_req_o,
  input  dre_pkg::alu_rsp_t  alu_rsp_i,
  output logic               done_o,
  output logic               out_valid_o,
  output dre_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);
  import dre_pkg::*;

  seq_state_e state_q, state_d;

  logic [CntW-1:0]   n_q;
  logic [SumW-1:0]   s_q;
  logic [SqSumW-1:0] qs_q;
  logic              ovf_q;
  logic [AluW-1:0]   rem_q, dvs_q, num_q, aux_q;
  logic [NHiW-1:0]   hi_q;
  logic [MulW-1:0]   gap_q;
  logic [DosW-1:0]   p_q, r2_q;
  logic [StepW-1:0]  step_q;

  logic              out_valid_q;
  out_item_t         out_q;

  logic              pass;
  logic              out_free;
  logic              load_out;
  logic              poly;
  logic [FracW-1:0]  maf;

  assign pass     = (r2_q >= thr_i);
  assign out_free = !out_valid_q || !out_stall_i;
  // Polymorphic only when 0 < sum < n*one.
  assign poly     = (s_q != '0) && alu_rsp_i.ge && (alu_rsp_i.res != '0);
  assign maf      = (p_q <= HalfQ15) ? p_q[FracW-1:0] : FracW'(OneQ15 - p_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_PDIV;
      ST_PDIV: if (step_q == StepW'(PDivSteps - 1)) state_d = ST_FMS;
      ST_FMS:  state_d = poly ? ST_SQ : ST_FIN;
      ST_SQ:   state_d = ST_NLO;
      ST_NLO:  state_d = ST_NHI;
      ST_NHI:  state_d = ST_NADD;
      ST_NADD: state_d = ST_NSUB;
      ST_NSUB: state_d = ST_DEN;
      ST_DEN:  state_d = ST_CMP;
      ST_CMP:  state_d = alu_rsp_i.ge ? ST_FIN : ST_RDIV;
      ST_RDIV: if (step_q == StepW'(RDivSteps - 1)) state_d = ST_FIN;
      ST_FIN:  if (!pass || out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    alu_req_o = '{op: ALU_MUL, opa: '0, opb: '0};
    done_o    = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_PDIV: alu_req_o = '{op: ALU_SUB, opa: rem_q, opb: dvs_q};
      ST_FMS:  alu_req_o = '{op: ALU_SUB, opa: AluW'({n_q, 15'd0}), opb: AluW'(s_q)};
      ST_SQ:   alu_req_o = '{op: ALU_MUL, opa: AluW'(s_q), opb: AluW'(s_q)};
      ST_NLO:  alu_req_o = '{op: ALU_MUL, opa: AluW'(n_q), opb: AluW'(qs_q[QLoW-1:0])};
      ST_NHI:  alu_req_o = '{op: ALU_MUL, opa: AluW'(n_q),
                             opb: AluW'(qs_q[SqSumW-1:QLoW])};
      ST_NADD: alu_req_o = '{op: ALU_ADD, opa: num_q, opb: AluW'({hi_q, {QLoW{1'b0}}})};
      ST_NSUB: alu_req_o = '{op: ALU_SUB, opa: num_q, opb: aux_q};
      ST_DEN:  alu_req_o = '{op: ALU_MUL, opa: AluW'(s_q), opb: AluW'(gap_q)};
      ST_CMP:  alu_req_o = '{op: ALU_SUB, opa: num_q, opb: dvs_q};
      ST_RDIV: alu_req_o = '{op: ALU_SUB, opa: {rem_q[AluW-2:0], 1'b0}, opb: dvs_q};
      ST_FIN: begin
        done_o   = !pass || out_free;
        load_out = pass && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers of the shared unit.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          n_q    <= stat_i.count;
          s_q    <= stat_i.sum;
          qs_q   <= stat_i.sq_sum;
          ovf_q  <= stat_i.overflow;
          rem_q  <= AluW'(stat_i.sum);
          dvs_q  <= AluW'({stat_i.count, 15'd0});
          p_q    <= '0;
          step_q <= '0;
        end
      end
      ST_PDIV: begin
        if (alu_rsp_i.ge) rem_q <= alu_rsp_i.res;
        p_q    <= {p_q[DosW-2:0], alu_rsp_i.ge};
        dvs_q  <= dvs_q >> 1;
        step_q <= step_q + 1'b1;
      end
      ST_FMS: begin
        gap_q <= alu_rsp_i.res[MulW-1:0];
        r2_q  <= '0;
      end
      ST_SQ:   aux_q <= alu_rsp_i.res;
      ST_NLO:  num_q <= alu_rsp_i.res;
      ST_NHI:  hi_q  <= alu_rsp_i.res[NHiW-1:0];
      ST_NADD: num_q <= alu_rsp_i.res;
      ST_NSUB: num_q <= alu_rsp_i.ge ? alu_rsp_i.res : '0;
      ST_DEN:  dvs_q <= alu_rsp_i.res;
      ST_CMP: begin
        if (alu_rsp_i.ge) r2_q <= OneQ15;
        rem_q  <= num_q;
        step_q <= '0;
      end
      ST_RDIV: begin
        rem_q  <= alu_rsp_i.ge ? alu_rsp_i.res : {rem_q[AluW-2:0], 1'b0};
        r2_q   <= {r2_q[DosW-2:0], alu_rsp_i.ge};
        step_q <= step_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= '{allele_freq: p_q, r2_value: r2_q, minor_freq: maf,
                 minor_freq_valid: maf_en_i, hap_count: n_q, count_overflow: ovf_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/dosage_r2_estimator.sv =====
// Dosage r2 estimator.
// Input channel (in_valid_i / in_stall_o / in_data_i): one haplotype dosage per
// transaction, Q1.15, with last set on the final haplotype of a variant.
// Dosages that are not last are taken one per cycle and accumulate through a
// two-stage square-and-add pipeline.
// Once a last transaction is taken, in_stall_o stays high while one shared
// multiply/add/subtract unit works out the variant: 16 restoring steps for
// the mean, then 8 steps of products and compares, then 15 steps for the r2
// ratio. When r2 saturates at one the ratio steps are skipped, and a
// monomorphic variant goes straight to the final step; the input reopens
// once the sequencer leaves its final step.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transaction per
// variant whose r2 reaches r2_threshold; other variants are dropped silently.
// The result waits in an output register while out_stall_i is high, and the
// sequencer holds in its final step until that register is free.
// APB port: r2_threshold at 0x0, report_maf at 0x4; write only while idle.
// Reset clears the accumulators, the registers and any pending result.
module dosage_r2_estimator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  dre_pkg::in_item_t  in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output dre_pkg::out_item_t out_data_o,
  input  logic               out_stall_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dre_pkg::*;

  logic       in_accept;
  logic       busy_q;
  logic [15:0] thr_q;
  logic       maf_en_q;
  logic       cfg_write;

  acc_stat_t  stat;
  logic       acc_done;
  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;
  logic       seq_done;

  assign in_accept  = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  // Hold off new dosages from the last transaction until the variant is done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_accept && in_data_i.last) begin
      busy_q <= 1'b1;
    end else if (seq_done) begin
      busy_q <= 1'b0;
    end
  end

  // Configuration registers; word select only, unknown offsets alias.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      maf_en_q <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THR: thr_q    <= pwdata[15:0];
        REG_MAF: maf_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THR: prdata = {16'd0, thr_q};
      REG_MAF: prdata = {31'd0, maf_en_q};
      default: prdata = '0;
    endcase
  end

  dre_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_accept),
    .item_i       (in_data_i),
    .stat_o       (stat),
    .done_o       (acc_done)
  );

  dre_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  dre_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (acc_done),
    .stat_i      (stat),
    .thr_i       (thr_q),
    .maf_en_i    (maf_en_q),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .done_o      (seq_done),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== rtl/core/dre_checker.sv =====
`include "dosage_r2_estimator_macros.svh"

module dre_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input dre_pkg::in_item_t  in_data_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input dre_pkg::out_item_t out_data_o,
  input logic               out_stall_i
);
  import dre_pkg::*;

  // A taken last transaction closes the input until the variant is done.
  `DRE_ASSERT_NEXT(a_last_stalls, in_valid_i && !in_stall_o && in_data_i.last, in_stall_o)

  // A result appears only at the end of a variant's computation.
  `DRE_ASSERT_NOW(a_result_after_busy, $rose(out_valid_o), $past(in_stall_o))

  // A stalled result holds.
  `DRE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Results stay within Q1.15 bounds and cover at least one haplotype.
  `DRE_ASSERT_NOW(a_out_range, out_valid_o, (out_data_o.r2_value <= OneQ15) && (out_data_o.allele_freq <= OneQ15) && (out_data_o.hap_count != '0))

endmodule

bind dosage_r2_estimator dre_checker u_dre_checker (.*);
